[rtl/acgf_pkg.sv]
// Package for the ARP cache gateway forwarder.
// Holds payload structs, operation codes and result codes; no dependencies.
package acgf_pkg;

    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned CfgWidth    = 32;

    typedef enum logic [1:0] {
        OP_ARP_ETH   = 2'd0,
        OP_ARP_RADIO = 2'd1,
        OP_IP        = 2'd2,
        OP_OTHER     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_REPLY   = 2'd1,
        KIND_OTHER   = 2'd2,
        KIND_RSVD    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_LOCAL      = 3'd1,
        ACT_REPLY_REQ  = 3'd2,
        ACT_FLOOD      = 3'd3,
        ACT_ETH_REPLY  = 3'd4,
        ACT_RADIO_REPLY = 3'd5,
        ACT_IP_ETH     = 3'd6,
        ACT_IP_RADIO   = 3'd7
    } t_action;

    localparam logic [1:0] CFG_OWN_IP    = 2'd0;
    localparam logic [1:0] CFG_BCAST_IP  = 2'd1;
    localparam logic [1:0] CFG_DEFAULT   = 2'd2;
    localparam logic [1:0] CFG_PORT_MASK = 2'd3;

    localparam logic [31:0] ALL_ONES_IP = 32'hffff_ffff;
    localparam logic [55:0] MASK48      = 56'h00_ffff_ffff_ffff;

    typedef struct packed {
        logic [1:0]  operation;
        logic [1:0]  arp_kind;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [55:0] sender_hw;
        logic [5:0]  arrival_port;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] flood_port_mask;
        logic        flood_to_ethernet;
        logic [55:0] next_hop_hw;
        logic [5:0]  out_port;
        logic        table_full;
    } t_out_item;

    // Classified work handed from the front end to the cache engine.
    typedef struct packed {
        logic        is_req;
        logic        is_reply;
        logic        is_ip;
        logic        is_eth;
        logic        is_local;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
        logic [55:0] hw;
        logic [5:0]  port;
        logic [31:0] fmask;
        logic        to_own;
    } t_job;

endpackage

[rtl/acgf_front.sv]
// Front end: accepts input beats, classifies them and queues jobs.
// Depends on acgf_pkg.
module acgf_front import acgf_pkg::*; #(
    parameter int unsigned RADIO_PORTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    input  logic [31:0] i_own_ip,
    input  logic [31:0] i_bcast_ip,
    input  logic [31:0] i_port_mask,
    output logic        o_job_valid,
    output t_job        o_job,
    input  logic        i_job_take
);
    localparam logic [32:0] LimitWide = (33'd1 << RADIO_PORTS) - 33'd1;
    localparam logic [31:0] PortLimit = LimitWide[31:0];

    // Two-entry job queue.
    t_job       r_q [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    t_job       n_job;
    logic       do_push, do_pop;

    always_comb begin
        logic eth;
        logic [31:0] base;
        eth = (i_item.operation == OP_ARP_ETH);
        base = i_port_mask & PortLimit;
        n_job.is_req    = (i_item.operation == OP_ARP_ETH || i_item.operation == OP_ARP_RADIO)
                          && i_item.arp_kind == KIND_REQUEST;
        n_job.is_reply  = (i_item.operation == OP_ARP_ETH || i_item.operation == OP_ARP_RADIO)
                          && i_item.arp_kind == KIND_REPLY;
        n_job.is_ip     = (i_item.operation == OP_IP);
        n_job.is_eth    = eth;
        n_job.is_local  = i_item.target_ip == i_own_ip || i_item.target_ip == ALL_ONES_IP
                          || i_item.target_ip == i_bcast_ip;
        n_job.sender_ip = i_item.sender_ip;
        n_job.target_ip = i_item.target_ip;
        n_job.hw        = eth ? (i_item.sender_hw & MASK48) : i_item.sender_hw;
        n_job.port      = eth ? 6'd0 : i_item.arrival_port;
        n_job.to_own    = i_item.target_ip == i_own_ip;
        if (!eth && i_item.arrival_port >= 6'd1 && i_item.arrival_port <= 6'(RADIO_PORTS))
            base = base & ~(32'd1 << (i_item.arrival_port - 6'd1));
        n_job.fmask = base;
    end

    assign full        = (r_cnt == 2'd2);
    assign do_push     = push && !full;
    assign o_job_valid = (r_cnt != 2'd0);
    assign do_pop      = i_job_take && o_job_valid;
    assign o_job       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_q[r_wr] <= n_job;
                r_wr <= ~r_wr;
            end
            if (do_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end
endmodule

[rtl/acgf_engine.sv]
// Back end: cache memory, sequential searches, learning and the result queue.
// Depends on acgf_pkg.
module acgf_engine import acgf_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_job_take,
    input  logic [31:0] i_default_ip,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_item
);
    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_WAIT, S_LEARN, S_RESULT
    } t_state;

    // One entry packed: ip, hw, eth, port, valid.
    typedef struct packed {
        logic [31:0] ip;
        logic [55:0] hw;
        logic        eth;
        logic [5:0]  port;
        logic        valid;
    } t_entry;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rdata;

    t_state      r_state;
    t_job        r_job;
    logic [CW-1:0] r_used;
    logic [CW-1:0] r_idx;
    logic [1:0]  r_phase;   // 0 sender search, 1 target search, 2 default search
    logic [31:0] r_key;
    logic        r_hit;
    logic [AW-1:0] r_hit_idx;
    logic        r_full;
    t_out_item   r_res;
    t_out_item   r_out;
    logic        r_res_valid;
    logic        r_wait_rd;
    logic        r_learn_new;

    assign o_job_take = (r_state == S_IDLE) && i_job_valid;
    assign empty = !r_res_valid;
    assign o_item = r_out;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[r_idx[AW-1:0]];
        if (r_state == S_LEARN && r_hit && !r_full) begin
            if (r_learn_new || r_job.is_reply) begin
                r_mem[r_hit_idx] <= '{ip: r_job.sender_ip, hw: r_job.hw, eth: r_job.is_eth,
                                      port: r_job.port, valid: 1'b1};
            end else if (r_job.is_eth) begin
                r_mem[r_hit_idx] <= '{ip: r_rdata.ip, hw: r_job.hw, eth: r_rdata.eth,
                                      port: r_rdata.port, valid: 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used <= '0;
            r_res_valid <= 1'b0;
            r_idx <= '0;
            r_wait_rd <= 1'b0;
        end else begin
            // The finished decision moves to the output register once it is free.
            if (r_state == S_RESULT && (!r_res_valid || pop)) begin
                r_out <= r_res;
                r_res_valid <= 1'b1;
            end else if (pop && r_res_valid) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        r_full <= 1'b0;
                        r_idx <= '0;
                        r_hit <= 1'b0;
                        r_wait_rd <= 1'b0;
                        if (i_job.is_req || i_job.is_reply) begin
                            r_res <= '0;
                            r_phase <= 2'd0;
                            r_key <= i_job.sender_ip;
                            r_state <= S_SEARCH;
                        end else if (i_job.is_ip && !i_job.is_local) begin
                            r_res <= '0;
                            r_phase <= 2'd1;
                            r_key <= i_job.target_ip;
                            r_state <= S_SEARCH;
                        end else begin
                            r_res <= '{action: (i_job.is_ip ? ACT_LOCAL : ACT_NONE),
                                       default: '0};
                            r_state <= S_RESULT;
                        end
                    end
                end
                // One entry read per cycle; the registered read data returns in the cycle after.
                S_SEARCH: begin
                    if (r_wait_rd && r_rdata.ip == r_key) begin
                        r_hit <= 1'b1;
                        r_hit_idx <= AW'(r_idx - CW'(1));
                        r_idx <= r_idx - CW'(1);
                        r_state <= S_WAIT;
                    end else if (r_idx >= r_used) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                        r_wait_rd <= 1'b1;
                    end
                end
                // Searching is done; the hit entry is re-read for its fields.
                S_WAIT: begin
                    r_wait_rd <= 1'b0;
                    if (!r_wait_rd) begin
                        if (r_phase == 2'd0) begin
                            if (r_hit) begin
                                r_learn_new <= 1'b0;
                                r_state <= S_LEARN;
                            end else if (r_used >= CW'(TABLE_ENTRIES)) begin
                                r_full <= 1'b1;
                                r_res.table_full <= 1'b1;
                                r_learn_new <= 1'b0;
                                r_state <= S_LEARN;
                            end else begin
                                r_learn_new <= 1'b1;
                                r_hit_idx <= AW'(r_used);
                                r_used <= r_used + CW'(1);
                                r_hit <= 1'b1;
                                r_state <= S_LEARN;
                            end
                        end else if (r_hit) begin
                            if (!r_job.is_ip || r_rdata.valid) begin
                                r_res.next_hop_hw <= r_rdata.hw;
                                if (r_rdata.eth) begin
                                    r_res.action <= r_job.is_ip ? ACT_IP_ETH : ACT_ETH_REPLY;
                                end else begin
                                    r_res.action <= r_job.is_ip ? ACT_IP_RADIO
                                                                : ACT_RADIO_REPLY;
                                    r_res.out_port <= r_rdata.port;
                                end
                            end
                            r_state <= S_RESULT;
                        end else if (r_phase == 2'd1 && r_job.is_ip) begin
                            r_phase <= 2'd2;
                            r_key <= i_default_ip;
                            r_idx <= '0;
                            r_state <= S_SEARCH;
                        end else begin
                            r_state <= S_RESULT;
                        end
                    end else begin
                        r_idx <= {{(CW-AW){1'b0}}, r_hit_idx};
                    end
                end
                S_LEARN: begin
                    r_wait_rd <= 1'b0;
                    if (r_job.is_req) begin
                        if (r_job.is_eth && r_job.to_own) begin
                            r_res.action <= ACT_REPLY_REQ;
                            r_res.next_hop_hw <= r_job.hw;
                        end else begin
                            r_res.action <= ACT_FLOOD;
                            r_res.flood_port_mask <= r_job.fmask;
                            r_res.flood_to_ethernet <= !r_job.is_eth;
                        end
                        r_state <= S_RESULT;
                    end else begin
                        r_phase <= 2'd1;
                        r_key <= r_job.target_ip;
                        r_hit <= 1'b0;
                        r_idx <= '0;
                        r_state <= S_SEARCH;
                    end
                end
                S_RESULT: begin
                    if (!r_res_valid || pop) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Full skips learning, so a learn state with full set must not write.
    // (The write block only writes when a hit or new slot exists.)

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(TABLE_ENTRIES)) else $error("fill count overran");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |=> r_state != S_IDLE) else $error("job taken but engine idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT && !r_res_valid) |=> r_res_valid)
        else $error("result lost");
endmodule

[rtl/arp_cache_gateway_forwarder_core.sv]
// ARP cache gateway forwarder, top level.
// Input queue: push/full with i_item; an item is taken when push && !full.
// Result queue: empty/pop with o_item; the oldest result shows while empty is
// low and leaves at an edge where pop is high.
// Configuration: i_cfg_we, i_cfg_index, i_cfg_data, written at an edge where i_cfg_we is high.
// Every input beat yields exactly one result beat.
// Search: the cache engine searches one entry a cycle over the used entries,
// up to two searches per item (sender then target, or target then default route).
// The front end queues two classified jobs so input can arrive during work.
// Reset clears the cache fill count, registers and queues; stored entries are
// not cleared because only filled entries are ever searched.
// When the receiver stalls, the engine holds its result, then the job queue
// fills and full rises; nothing is dropped.
// Depends on acgf_pkg, acgf_front, acgf_engine.
module arp_cache_gateway_forwarder_core import acgf_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned RADIO_PORTS   = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  t_in_item               i_item,
    output logic                   empty,
    input  logic                   pop,
    output t_out_item              o_item,
    input  logic                   i_cfg_we,
    input  logic [CfgIdxWidth-1:0] i_cfg_index,
    input  logic [CfgWidth-1:0]    i_cfg_data
);
    logic [31:0] r_own_ip, r_bcast_ip, r_default_ip, r_port_mask;
    logic job_valid, job_take;
    t_job job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip <= '0;
            r_bcast_ip <= '0;
            r_default_ip <= '0;
            r_port_mask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OWN_IP:    r_own_ip <= i_cfg_data;
                CFG_BCAST_IP:  r_bcast_ip <= i_cfg_data;
                CFG_DEFAULT:   r_default_ip <= i_cfg_data;
                CFG_PORT_MASK: r_port_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    acgf_front #(.RADIO_PORTS(RADIO_PORTS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_item(i_item),
        .i_own_ip(r_own_ip), .i_bcast_ip(r_bcast_ip), .i_port_mask(r_port_mask),
        .o_job_valid(job_valid), .o_job(job), .i_job_take(job_take)
    );

    acgf_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_job_valid(job_valid), .i_job(job),
        .o_job_take(job_take), .i_default_ip(r_default_ip),
        .empty(empty), .pop(pop), .o_item(o_item)
    );
endmodule

[verif/arp_cache_gateway_forwarder_core_test.sv]
// Self-checking testbench for arp_cache_gateway_forwarder_core.
// Depends on acgf_pkg and the core; it predicts each result beat with its own
// cache model and drives both queue sides with random gaps and stalls.
`timescale 1ns / 100ps

module arp_cache_gateway_forwarder_core_test;
    import acgf_pkg::*;

    localparam int unsigned CacheDepth = 64;
    localparam int unsigned CycleLimit = 1200000;
    localparam int unsigned TailCycles = 300;

    // Keeps the expected forwarding decisions and a shadow copy of the ARP cache.
    class forward_decision_board;
        logic [31:0] own_ip, bcast_ip, default_ip, port_mask;
        logic [31:0] cache_ip[CacheDepth];
        logic [55:0] cache_hw[CacheDepth];
        bit          cache_eth[CacheDepth];
        logic [5:0]  cache_port[CacheDepth];
        bit          cache_valid[CacheDepth];
        int          used;
        t_out_item   pending_decisions[$];
        int          mismatches, results, full_seen;

        function new();
            own_ip = '0;
            bcast_ip = '0;
            default_ip = '0;
            port_mask = '0;
            used = 0;
            mismatches = 0;
            results = 0;
            full_seen = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_OWN_IP:    own_ip = val;
                CFG_BCAST_IP:  bcast_ip = val;
                CFG_DEFAULT:   default_ip = val;
                CFG_PORT_MASK: port_mask = val;
                default: ;
            endcase
        endfunction

        function int find_ip(logic [31:0] ip);
            for (int i = 0; i < used; i++) begin
                if (cache_ip[i] == ip) return i;
            end
            return -1;
        endfunction

        function void store_entry(int k, logic [31:0] ip, logic [55:0] hw, bit eth,
                                  logic [5:0] port);
            cache_ip[k] = ip;
            cache_hw[k] = hw;
            cache_eth[k] = eth;
            cache_port[k] = eth ? 6'd0 : port;
            cache_valid[k] = 1'b1;
        endfunction

        function void note_input(t_in_item it);
            t_out_item   r;
            int          k;
            bit          eth;
            bit          is_arp;
            logic [55:0] hw;
            r = '0;
            eth = (it.operation == OP_ARP_ETH);
            is_arp = eth || (it.operation == OP_ARP_RADIO);
            hw = eth ? (it.sender_hw & MASK48) : it.sender_hw;
            if (is_arp && it.arp_kind == KIND_REQUEST) begin
                k = find_ip(it.sender_ip);
                if (k >= 0) begin
                    // A radio request from a known sender leaves the entry alone.
                    if (eth) begin
                        cache_hw[k] = hw;
                        cache_valid[k] = 1'b1;
                    end
                end else if (used >= CacheDepth) begin
                    r.table_full = 1'b1;
                end else begin
                    store_entry(used, it.sender_ip, hw, eth, it.arrival_port);
                    used++;
                end
                if (eth && it.target_ip == own_ip) begin
                    r.action = ACT_REPLY_REQ;
                    r.next_hop_hw = hw;
                end else begin
                    r.action = ACT_FLOOD;
                    r.flood_port_mask = port_mask;
                    if (!eth) begin
                        if (it.arrival_port >= 1 && it.arrival_port <= 32)
                            r.flood_port_mask &= ~(32'h1 << (it.arrival_port - 1));
                        r.flood_to_ethernet = 1'b1;
                    end
                end
            end else if (is_arp && it.arp_kind == KIND_REPLY) begin
                k = find_ip(it.sender_ip);
                if (k < 0 && used < CacheDepth) begin
                    k = used;
                    used++;
                end
                if (k < 0) r.table_full = 1'b1;
                else store_entry(k, it.sender_ip, hw, eth, it.arrival_port);
                k = find_ip(it.target_ip);
                if (k >= 0) begin
                    r.next_hop_hw = cache_hw[k];
                    if (cache_eth[k]) begin
                        r.action = ACT_ETH_REPLY;
                    end else begin
                        r.action = ACT_RADIO_REPLY;
                        r.out_port = cache_port[k];
                    end
                end
            end else if (it.operation == OP_IP) begin
                if (it.target_ip == own_ip || it.target_ip == ALL_ONES_IP ||
                    it.target_ip == bcast_ip) begin
                    r.action = ACT_LOCAL;
                end else begin
                    k = find_ip(it.target_ip);
                    if (k < 0) k = find_ip(default_ip);
                    if (k >= 0 && cache_valid[k]) begin
                        r.next_hop_hw = cache_hw[k];
                        if (cache_eth[k]) begin
                            r.action = ACT_IP_ETH;
                        end else begin
                            r.action = ACT_IP_RADIO;
                            r.out_port = cache_port[k];
                        end
                    end
                end
            end
            pending_decisions.push_back(r);
        endfunction

        function void report(string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            results++;
            if (got.table_full === 1'b1) full_seen++;
            if (pending_decisions.size() == 0) begin
                report("result beat with no decision pending");
                return;
            end
            want = pending_decisions.pop_front();
            if (got.action !== want.action)
                report($sformatf("action %0d, want %0d", got.action, want.action));
            if (got.flood_port_mask !== want.flood_port_mask)
                report($sformatf("flood mask %h, want %h", got.flood_port_mask,
                                 want.flood_port_mask));
            if (got.flood_to_ethernet !== want.flood_to_ethernet)
                report($sformatf("flood to ethernet %b, want %b", got.flood_to_ethernet,
                                 want.flood_to_ethernet));
            if (got.next_hop_hw !== want.next_hop_hw)
                report($sformatf("next hop %h, want %h", got.next_hop_hw,
                                 want.next_hop_hw));
            if (got.out_port !== want.out_port)
                report($sformatf("out port %0d, want %0d", got.out_port, want.out_port));
            if (got.table_full !== want.table_full)
                report($sformatf("table full %b, want %b", got.table_full,
                                 want.table_full));
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    t_in_item               i_item = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    t_out_item              o_item;
    logic                   i_cfg_we = 1'b0;
    logic [CfgIdxWidth-1:0] i_cfg_index = '0;
    logic [CfgWidth-1:0]    i_cfg_data = '0;

    forward_decision_board board = new();
    int unsigned cycles = 0;
    int          items_sent = 0;
    logic [31:0] host_base = 32'h0a01_0000;

    arp_cache_gateway_forwarder_core dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one, often none at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Result side: pop changes at the falling edge, beats are taken at the rising edge.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                pop = 1'b0;
            end else begin
                stall = pick_gap();
                pop = (stall == 0);
            end
            @(posedge i_clk);
            if (pop && !empty) board.check_result(o_item);
        end
    end

    // Called at a falling edge; returns at a falling edge after the beat is taken.
    task automatic send_item(t_in_item it);
        int gap;
        i_item = it;
        push = 1'b1;
        do @(posedge i_clk); while (full);
        board.note_input(it);
        items_sent++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic write_register(logic [1:0] idx, logic [31:0] val);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        board.set_register(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic wait_idle();
        push = 1'b0;
        while (board.pending_decisions.size() != 0) @(negedge i_clk);
        repeat (TailCycles) @(negedge i_clk);
    endtask

    task automatic set_all(logic [31:0] own, logic [31:0] bc, logic [31:0] dflt,
                           logic [31:0] mask);
        write_register(CFG_OWN_IP, own);
        write_register(CFG_BCAST_IP, bc);
        write_register(CFG_DEFAULT, dflt);
        write_register(CFG_PORT_MASK, mask);
    endtask

    function automatic t_in_item make_item(logic [1:0] op, logic [1:0] kind,
                                           logic [31:0] sip, logic [31:0] tip,
                                           logic [55:0] hw, logic [5:0] port);
        t_in_item it;
        it.operation = op;
        it.arp_kind = kind;
        it.sender_ip = sip;
        it.target_ip = tip;
        it.sender_hw = hw;
        it.arrival_port = port;
        return it;
    endfunction

    function automatic logic [55:0] rand_hw();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[55:0];
    endfunction

    function automatic logic [31:0] pick_ip(int hosts);
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return host_base + $urandom_range(0, hosts - 1);
        if (r < 89) return board.own_ip;
        if (r < 92) return board.bcast_ip;
        if (r < 94) return ALL_ONES_IP;
        return $urandom();
    endfunction

    // Mostly well-formed ARP and IP traffic over a small host pool, some noise.
    function automatic t_in_item random_item(int hosts);
        t_in_item it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) it.operation = OP_ARP_ETH;
        else if (r < 60) it.operation = OP_ARP_RADIO;
        else if (r < 94) it.operation = OP_IP;
        else it.operation = OP_OTHER;
        r = $urandom_range(0, 99);
        if (r < 50) it.arp_kind = KIND_REQUEST;
        else if (r < 92) it.arp_kind = KIND_REPLY;
        else it.arp_kind = 2'($urandom_range(2, 3));
        it.sender_ip = pick_ip(hosts);
        it.target_ip = pick_ip(hosts);
        it.sender_hw = rand_hw();
        if ($urandom_range(0, 9) < 8) it.arrival_port = 6'($urandom_range(1, 32));
        else it.arrival_port = 6'($urandom_range(0, 63));
        return it;
    endfunction

    initial begin
        logic [31:0] own, bc, dflt;
        logic [31:0] h1, h2, h3, h4, h5;
        int          hosts;
        h1 = host_base + 1;
        h2 = host_base + 2;
        h3 = host_base + 3;
        h4 = host_base + 4;
        h5 = host_base + 5;
        own = 32'hc0a8_0001;
        bc = 32'hc0a8_00ff;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        set_all(own, bc, h2, 32'hffff_ffff);
        send_item(make_item(OP_IP, KIND_REQUEST, '0, h1, '0, '0));
        send_item(make_item(OP_ARP_ETH, KIND_REQUEST, h1, own, 56'hff_ffff_ffff_ffff, 6'd9));
        send_item(make_item(OP_ARP_ETH, KIND_REQUEST, h2, h5, rand_hw(), 6'd0));
        send_item(make_item(OP_ARP_RADIO, KIND_REQUEST, h3, own, rand_hw(), 6'd5));
        send_item(make_item(OP_ARP_RADIO, KIND_REQUEST, h4, h1, rand_hw(), 6'd0));
        send_item(make_item(OP_ARP_RADIO, KIND_REQUEST, h4, h1, rand_hw(), 6'd32));
        send_item(make_item(OP_ARP_RADIO, KIND_REQUEST, h4, h1, rand_hw(), 6'd63));
        send_item(make_item(OP_ARP_RADIO, KIND_REQUEST, h4, h1, rand_hw(), 6'd1));
        // Known senders: Ethernet refreshes the address, radio keeps the entry.
        send_item(make_item(OP_ARP_ETH, KIND_REQUEST, h1, own, 56'h00_1234_5678_9abc, '0));
        send_item(make_item(OP_ARP_RADIO, KIND_REQUEST, h3, h2, rand_hw(), 6'd17));
        send_item(make_item(OP_ARP_ETH, KIND_REPLY, h5, h1, rand_hw(), '0));
        send_item(make_item(OP_ARP_RADIO, KIND_REPLY, h2, h3, 56'hff_0000_0000_0001, 6'd7));
        send_item(make_item(OP_ARP_ETH, KIND_REPLY, h4, 32'h0bad_0001, rand_hw(), '0));
        send_item(make_item(OP_IP, KIND_REQUEST, '0, own, '0, '0));
        send_item(make_item(OP_IP, KIND_REQUEST, '0, bc, '0, '0));
        send_item(make_item(OP_IP, KIND_REQUEST, '0, ALL_ONES_IP, '0, '0));
        send_item(make_item(OP_IP, KIND_REPLY, '0, h3, '0, '0));
        send_item(make_item(OP_IP, KIND_REQUEST, '0, h1, '0, '0));
        send_item(make_item(OP_IP, KIND_OTHER, '0, 32'h0bad_0002, '0, '0));
        send_item(make_item(OP_ARP_ETH, KIND_OTHER, h1, h2, rand_hw(), '0));
        send_item(make_item(OP_ARP_RADIO, KIND_RSVD, h1, h2, rand_hw(), 6'd3));
        send_item(make_item(OP_OTHER, KIND_REQUEST, h1, h2, rand_hw(), 6'd3));
        wait_idle();

        // The pool grows phase by phase so the cache fills up late in the run.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_all(host_base + 7, bc, host_base + 3, $urandom());
                1: set_all('0, '0, '0, '0);
                2: set_all($urandom(), host_base + 9, host_base + 1, 32'h0000_ffff);
                3: set_all(ALL_ONES_IP, ALL_ONES_IP, ALL_ONES_IP, ALL_ONES_IP);
                default: set_all(host_base + 2, $urandom(), 32'h0bad_0003, $urandom());
            endcase
            hosts = 30 + 25 * phase;
            repeat (206) send_item(random_item(hosts));
            wait_idle();
        end

        $display("sent %0d items, checked %0d result beats, %0d with table full",
                 items_sent, board.results, board.full_seen);
        $display("cache entries learned: %0d, mismatches: %0d", board.used,
                 board.mismatches);
        if (board.mismatches == 0 && board.pending_decisions.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/acgf_pkg.sv
rtl/acgf_front.sv
rtl/acgf_engine.sv
rtl/arp_cache_gateway_forwarder_core.sv
verif/arp_cache_gateway_forwarder_core_test.sv
